[hdl/assert_macros.svh]
// Assertion macros used by the allocator's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Consequent must hold whenever the antecedent does
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/nfba_pkg.sv]
// Shared types and constants of the next-fit identifier allocator.
package nfba_pkg;

    // Bitmap word geometry
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int ID_OUT_W = 8;

    // Operation codes carried in tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Outcome of searching one bitmap word
    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  idx;
        logic [WORD_W-1:0] marked;
    } t_scan_res;

endpackage

[hdl/nfba_ram.sv]
// Generic single-port-write, registered-read RAM.
module nfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/nfba_scan.sv]
// Lowest-free-bit search over one bitmap word.
module nfba_scan (
    input  logic [nfba_pkg::WORD_W-1:0] i_word,
    input  logic [nfba_pkg::WORD_W-1:0] i_mask,
    output nfba_pkg::t_scan_res         o_res
);

    logic [nfba_pkg::WORD_W-1:0] free_bits;
    logic [nfba_pkg::WORD_W-1:0] lowest;
    logic [nfba_pkg::BIT_W-1:0]  idx;

    // Isolate the lowest clear bit inside the window
    assign free_bits = ~i_word & i_mask;
    assign lowest    = free_bits & (~free_bits + nfba_pkg::WORD_W'(1));

    // Encode the one-hot position; each output bit is an OR over independent taps
    always_comb begin
        idx = '0;
        for (int b = 0; b < nfba_pkg::WORD_W; b++) begin
            if (lowest[b]) begin
                idx = idx | nfba_pkg::BIT_W'(b);
            end
        end
    end

    assign o_res.found  = |free_bits;
    assign o_res.idx    = idx;
    assign o_res.marked = i_word | lowest;

endmodule

[hdl/next_fit_bitmap_id_allocator.sv]
// Top level of the next-fit bitmap identifier allocator.
// Next-fit identifier allocator. The used marks live in a RAM of 32-bit words
// (ceil(NUM_IDS/32) words); a search pointer remembers where the last grant ended.
// After reset a clearing pass writes every word to zero, one word a cycle, and no
// item is taken meanwhile. An allocate reads one word per cycle through the single
// RAM read port from the pointer's word onwards, wrapping, and finishes with the
// low part of the starting word. A free is a read-modify-write of one word; a free
// of an identifier out of range writes nothing. One item is handled at a time;
// the result sits in an output register so the next item can be accepted while
// it waits. Slave side: tuser[0] = kind (0 allocate, 1 free), tdata[7:0] =
// identifier to free. Master side: tuser[0] = granted, tdata[7:0] = identifier
// handed out (zero for a free or a failure).
`include "assert_macros.svh"

module next_fit_bitmap_id_allocator #(
    parameter int NUM_IDS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] release_id
    input  logic [0:0] i_s_tuser,   // [0] kind
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] given_id
    output logic [0:0] o_m_tuser    // [0] granted
);

    localparam int NW      = (NUM_IDS + nfba_pkg::WORD_W - 1) / nfba_pkg::WORD_W;
    localparam int WAW     = (NW > 1) ? $clog2(NW) : 1;
    localparam int ID_W    = WAW + nfba_pkg::BIT_W;
    localparam int STEP_W  = $clog2(NW + 1);
    localparam int LAST_BITS = NUM_IDS - (NW - 1) * nfba_pkg::WORD_W;
    localparam logic [nfba_pkg::WORD_W-1:0] LAST_MASK =
        nfba_pkg::WORD_W'((64'd1 << LAST_BITS) - 64'd1);

    nfba_pkg::t_state r_state, n_state;
    logic [ID_W-1:0]   r_ptr, n_ptr;
    logic [WAW-1:0]    r_clr, n_clr;
    logic [WAW-1:0]    r_word, n_word;
    logic [STEP_W-1:0] r_step, n_step;
    logic [nfba_pkg::BIT_W-1:0] r_bit, n_bit;
    logic              r_res_granted, n_res_granted;
    logic [7:0]        r_res_id, n_res_id;
    logic              r_out_valid, n_out_valid;
    logic              r_out_granted, n_out_granted;
    logic [7:0]        r_out_id, n_out_id;

    logic                         s_accept;
    logic                         out_free;
    logic                         rel_in_range;
    logic [ID_W+7:0]              rel_ext;
    logic [ID_W+7:0]              id_ext;
    logic [ID_W-1:0]              found_id;
    logic [WAW-1:0]               next_word;
    logic [nfba_pkg::WORD_W-1:0]  hi_mask;
    logic [nfba_pkg::WORD_W-1:0]  win_mask;
    logic                         ram_we;
    logic [WAW-1:0]               ram_waddr;
    logic [nfba_pkg::WORD_W-1:0]  ram_wdata;
    logic [WAW-1:0]               ram_raddr;
    logic [nfba_pkg::WORD_W-1:0]  ram_rdata;
    nfba_pkg::t_scan_res          scan_res;

    // Bitmap store
    nfba_ram #(
        .WIDTH (nfba_pkg::WORD_W),
        .DEPTH (NW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Search window: from the pointer's bit on the first visit, below it on the last, top word cut to NUM_IDS
    assign hi_mask = ~nfba_pkg::WORD_W'(0) << r_ptr[nfba_pkg::BIT_W-1:0];
    always_comb begin
        win_mask = ~nfba_pkg::WORD_W'(0);
        if (r_step == '0) begin
            win_mask = hi_mask;
        end else if (r_step == STEP_W'(NW)) begin
            win_mask = ~hi_mask;
        end
        if (r_word == WAW'(NW - 1)) begin
            win_mask = win_mask & LAST_MASK;
        end
    end

    nfba_scan u_scan (
        .i_word (ram_rdata),
        .i_mask (win_mask),
        .o_res  (scan_res)
    );

    // Handshake and helpers
    assign o_s_tready   = (r_state == nfba_pkg::S_IDLE);
    assign s_accept     = i_s_tvalid && o_s_tready;
    assign out_free     = !r_out_valid || i_m_tready;
    assign rel_in_range = (32'(i_s_tdata) < NUM_IDS);
    assign rel_ext      = (ID_W + 8)'(i_s_tdata);
    assign found_id     = {r_word, scan_res.idx};
    assign id_ext       = (ID_W + 8)'(found_id);
    assign next_word    = (r_word == WAW'(NW - 1)) ? '0 : r_word + WAW'(1);

    // Controller
    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_clr         = r_clr;
        n_word        = r_word;
        n_step        = r_step;
        n_bit         = r_bit;
        n_res_granted = r_res_granted;
        n_res_id      = r_res_id;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_granted = r_out_granted;
        n_out_id      = r_out_id;
        ram_we        = 1'b0;
        ram_waddr     = r_word;
        ram_wdata     = '0;
        ram_raddr     = r_ptr[ID_W-1:nfba_pkg::BIT_W];

        case (r_state)
            nfba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + WAW'(1);
                if (r_clr == WAW'(NW - 1)) begin
                    n_state = nfba_pkg::S_IDLE;
                end
            end
            nfba_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser[0] == nfba_pkg::OP_ALLOC) begin
                        n_word  = r_ptr[ID_W-1:nfba_pkg::BIT_W];
                        n_step  = '0;
                        n_state = nfba_pkg::S_SCAN;
                    end else if (rel_in_range) begin
                        ram_raddr = rel_ext[ID_W-1:nfba_pkg::BIT_W];
                        n_word    = rel_ext[ID_W-1:nfba_pkg::BIT_W];
                        n_bit     = rel_ext[nfba_pkg::BIT_W-1:0];
                        n_state   = nfba_pkg::S_FREE;
                    end else begin
                        n_res_granted = 1'b0;
                        n_res_id      = '0;
                        n_state       = nfba_pkg::S_DONE;
                    end
                end
            end
            nfba_pkg::S_SCAN: begin
                ram_raddr = next_word;
                if (scan_res.found) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_word;
                    ram_wdata     = scan_res.marked;
                    n_ptr         = (found_id == ID_W'(NUM_IDS - 1)) ? '0
                                                                     : found_id + ID_W'(1);
                    n_res_granted = 1'b1;
                    n_res_id      = id_ext[7:0];
                    n_state       = nfba_pkg::S_DONE;
                end else if (r_step == STEP_W'(NW)) begin
                    n_res_granted = 1'b0;
                    n_res_id      = '0;
                    n_state       = nfba_pkg::S_DONE;
                end else begin
                    n_word = next_word;
                    n_step = r_step + STEP_W'(1);
                end
            end
            nfba_pkg::S_FREE: begin
                ram_we        = 1'b1;
                ram_waddr     = r_word;
                ram_wdata     = ram_rdata & ~(nfba_pkg::WORD_W'(1) << r_bit);
                n_res_granted = 1'b1;
                n_res_id      = '0;
                n_state       = nfba_pkg::S_DONE;
            end
            nfba_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_res_granted;
                    n_out_id      = r_res_id;
                    n_state       = nfba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfba_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfba_pkg::S_CLEAR;
            r_ptr       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word        <= n_word;
        r_step        <= n_step;
        r_bit         <= n_bit;
        r_res_granted <= n_res_granted;
        r_res_id      <= n_res_id;
        r_out_granted <= n_out_granted;
        r_out_id      <= n_out_id;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_id;
    assign o_m_tuser[0] = r_out_granted;

    // Checks
    `ASSERT_HOLDS(a_ptr_range, i_clk, i_rst_n, (32'(r_ptr) < NUM_IDS), "search pointer out of range")
    `ASSERT_IMPLIES(a_step_bound, i_clk, i_rst_n, (r_state == nfba_pkg::S_SCAN), (32'(r_step) <= NW), "scan ran past the wrap")
    `ASSERT_IMPLIES(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == nfba_pkg::S_DONE), "result raised outside completion")
    `ASSERT_IMPLIES(a_ptr_moves_on_grant, i_clk, i_rst_n, (r_ptr != $past(r_ptr)), ($past(r_state) == nfba_pkg::S_SCAN) && r_res_granted, "pointer moved without a grant")

endmodule

[dv/next_fit_bitmap_id_allocator_tb.sv]
// Self-checking testbench for the next-fit bitmap identifier allocator.
`timescale 1ns / 100ps

module next_fit_bitmap_id_allocator_tb;

    localparam int NUM_IDS        = 256;
    localparam int RST_CYCLES     = 9;
    localparam int MAX_GAP        = 19;
    localparam int LONG_STALL_AT  = 40;     // result count at which the sink holds off
    localparam int LONG_STALL_LEN = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTS     = 50;

    // One request towards the allocator
    typedef struct packed {
        logic       kind;
        logic [7:0] rel_id;
        logic       wait_idle;  // sender pauses until all grants are back
    } t_id_req;

    // One grant coming back
    typedef struct packed {
        logic       granted;
        logic [7:0] given_id;
    } t_id_grant;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic [0:0] s_tuser  = '0;
    logic       m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [0:0] o_m_tuser;

    t_id_req   req_q[$];
    t_id_grant grant_q[$];

    // Shadow state of the allocator
    bit [NUM_IDS-1:0] shadow_used;
    int               shadow_ptr;

    int      err_count    = 0;
    int      idle_cycles  = 0;
    int      result_count = 0;
    int      sent_count   = 0;
    int      tx_wait      = 0;
    int      rx_wait      = 0;
    int      stall_left   = 0;
    bit      tx_busy      = 1'b0;
    bit      rx_busy      = 1'b0;
    bit      offering     = 1'b0;
    t_id_req cur_req;

    next_fit_bitmap_id_allocator #(
        .NUM_IDS(NUM_IDS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),     // [7:0] release_id
        .i_s_tuser (s_tuser),     // [0] kind
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),   // [7:0] given_id
        .o_m_tuser (o_m_tuser)    // [0] granted
    );

    always #5 i_clk = ~i_clk;

    // Apply one accepted request to the shadow state, queue the grant it yields
    task automatic predict_grant(input t_id_req r);
        t_id_grant g;
        int        probe;
        bit        found;
        g     = '0;
        found = 1'b0;
        if (r.kind == nfba_pkg::OP_ALLOC) begin
            probe = shadow_ptr;
            for (int n = 0; n < NUM_IDS && !found; n++) begin
                if (!shadow_used[probe[7:0]]) begin
                    found                   = 1'b1;
                    shadow_used[probe[7:0]] = 1'b1;
                    shadow_ptr              = (probe + 1) % NUM_IDS;
                    g.granted               = 1'b1;
                    g.given_id              = probe[7:0];
                end else begin
                    probe = (probe + 1) % NUM_IDS;
                end
            end
        end else if (int'(r.rel_id) < NUM_IDS) begin
            shadow_used[r.rel_id] = 1'b0;
            g.granted             = 1'b1;
        end
        grant_q.push_back(g);
    endtask

    task automatic report_mismatch(input string field, input int exp_val, input int got_val);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] grant %0d: %s expected %0d, got %0d",
                     $realtime, result_count, field, exp_val, got_val);
    endtask

    task automatic add_req(input logic kind, input logic [7:0] rel_id,
                           input bit wait_idle = 1'b0);
        t_id_req r;
        r.kind      = kind;
        r.rel_id    = rel_id;
        r.wait_idle = wait_idle;
        req_q.push_back(r);
    endtask

    function automatic int draw_gap(input bit busy);
        return busy ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Driver: offers queued requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predict_grant(cur_req);
                sent_count++;
                if (sent_count % 64 == 0)
                    tx_busy = 1'($urandom_range(0, 1));
                tx_wait  = draw_gap(tx_busy);
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (req_q.size() > 0 &&
                             !(req_q[0].wait_idle && grant_q.size() != 0)) begin
                    cur_req  = req_q.pop_front();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tdata  <= cur_req.rel_id;
            s_tuser  <= cur_req.kind;
        end
    end

    // Monitor: checks grants and throttles tready, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                t_id_grant exp_g;
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected item, granted", -1, int'(o_m_tuser[0]));
                end else begin
                    exp_g = grant_q.pop_front();
                    if (o_m_tuser[0] !== exp_g.granted)
                        report_mismatch("granted", int'(exp_g.granted), int'(o_m_tuser[0]));
                    if (o_m_tdata !== exp_g.given_id)
                        report_mismatch("given_id", int'(exp_g.given_id), int'(o_m_tdata));
                end
                result_count++;
                if (result_count % 64 == 0)
                    rx_busy = 1'($urandom_range(0, 1));
                rx_wait = draw_gap(rx_busy);
                if (result_count == LONG_STALL_AT)
                    stall_left = LONG_STALL_LEN;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0 && stall_left == 0);
        end
    end

    // Watchdog: ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int alloc_pct;
        shadow_used = '0;
        shadow_ptr  = 0;

        // Directed: next-fit order, free of a free id, extremes of the id field
        add_req(nfba_pkg::OP_ALLOC, 8'd0);
        add_req(nfba_pkg::OP_ALLOC, 8'hFF);          // id field ignored on allocate
        add_req(nfba_pkg::OP_ALLOC, 8'h5A);
        add_req(nfba_pkg::OP_FREE,  8'd1);
        add_req(nfba_pkg::OP_FREE,  8'd1);           // already free
        add_req(nfba_pkg::OP_ALLOC, 8'd0);           // pointer has moved on, not back to 1
        add_req(nfba_pkg::OP_FREE,  8'd0);
        add_req(nfba_pkg::OP_FREE,  8'hFF);          // top id, never handed out
        add_req(nfba_pkg::OP_FREE,  8'hAA);
        add_req(nfba_pkg::OP_FREE,  8'h55);
        add_req(nfba_pkg::OP_FREE,  8'd2);
        add_req(nfba_pkg::OP_ALLOC, 8'd0);
        add_req(nfba_pkg::OP_FREE,  8'd3);

        // Fill up the map until allocations run dry, a few frees mixed in
        for (int i = 0; i < 300; i++) begin
            if ($urandom_range(0, 99) < 5)
                add_req(nfba_pkg::OP_FREE, 8'($urandom_range(0, NUM_IDS - 1)));
            else
                add_req(nfba_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
        end

        // Mostly frees; the first waits until the block has gone quiet
        add_req(nfba_pkg::OP_FREE, 8'($urandom_range(0, NUM_IDS - 1)), 1'b1);
        for (int i = 0; i < 299; i++) begin
            if ($urandom_range(0, 99) < 20)
                add_req(nfba_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
            else
                add_req(nfba_pkg::OP_FREE, 8'($urandom_range(0, NUM_IDS - 1)));
        end

        // Mixed traffic in blocks of varying allocate share
        for (int blk = 0; blk < 15; blk++) begin
            alloc_pct = $urandom_range(30, 80);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 99) < alloc_pct)
                    add_req(nfba_pkg::OP_ALLOC, 8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 9) == 0)
                    add_req(nfba_pkg::OP_FREE, $urandom_range(0, 1) ? 8'hFF : 8'h00);
                else
                    add_req(nfba_pkg::OP_FREE, 8'($urandom_range(0, NUM_IDS - 1)));
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (req_q.size() != 0 || offering || grant_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
